[sv/dps_pkg.sv]
// Package with the shared types and codes of the dynamic priority scheduler.
package dps_pkg;

	typedef logic signed [15:0] prio_t;
	typedef logic [15:0] rtime_t;
	typedef logic [2:0] slot_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam prio_t PRIO_MIN = 16'sh8000;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_UPD   = 4'b1000
	} state_t;

endpackage

[sv/dps_if.sv]
// Valid/ready channel interfaces for the scheduler request and result streams.
interface dps_req_if;
	logic valid;
	logic ready;
	logic operation;
	dps_pkg::slot_t slot;
	dps_pkg::prio_t start_priority;
	dps_pkg::rtime_t run_time;

	modport source (output valid, operation, slot, start_priority, run_time, input ready);
	modport sink (input valid, operation, slot, start_priority, run_time, output ready);
endinterface

interface dps_rsp_if;
	logic valid;
	logic ready;
	logic ran;
	dps_pkg::slot_t chosen_slot;
	dps_pkg::prio_t new_priority;
	dps_pkg::rtime_t time_left;
	logic finished;

	modport source (output valid, ran, chosen_slot, new_priority, time_left, finished,
		input ready);
	modport sink (input valid, ran, chosen_slot, new_priority, time_left, finished,
		output ready);
endinterface

[sv/dynamic_priority_scheduler_unit.sv]
// Dynamic priority scheduler: slot table in memory scanned by one shared compare unit.
//
// The block takes requests on req and returns exactly one result per request on rsp,
// both valid/ready channels; a transaction moves when valid and ready are high together.
// A load request writes one slot of the table (when its index is below SLOTS) and
// returns an echo of its fields in the cycle after acceptance.
// A tick request scans the slot table one entry per cycle through a single memory read
// port and a single priority comparator, checks the tie against the slot that ran last,
// writes the chosen slot back and presents its result. A tick goes through scan, drain
// and update states; the scan length is set by the one-entry-per-cycle read port.
// req.ready is high only while the sequencer is idle and the result register is free
// or being emptied in the same cycle, so loads can be taken back to back.
// When the receiver stalls, the result is held in the output register; a finished
// scan waits in its update step until that register is free.
// Reset (arst_n low) clears per-slot valid bits, so every slot reads as empty at once,
// with no clearing pass; last-run tracking is cleared too.
module dynamic_priority_scheduler_unit #(
	parameter int SLOTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	dps_req_if.sink   req,
	dps_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	dps_pkg::state_t state_q;

	// Slot table memories and their valid bits.
	dps_pkg::prio_t prio_mem [SLOTS];
	dps_pkg::rtime_t time_mem [SLOTS];
	logic [SLOTS-1:0] valid_q;

	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] last_slot_q;
	logic last_valid_q;

	// Read data stage.
	logic cmp_s1;
	logic [IDX_W-1:0] idx_s1;
	logic vld_s1;
	dps_pkg::prio_t prio_s1;
	dps_pkg::rtime_t time_s1;

	// Scan results.
	logic found_q;
	logic [IDX_W-1:0] best_idx_q;
	dps_pkg::prio_t best_prio_q;
	dps_pkg::rtime_t best_time_q;
	logic last_occ_q;
	dps_pkg::prio_t last_prio_q;
	dps_pkg::rtime_t last_time_q;

	// Output register.
	logic ov_q;
	logic ran_q;
	dps_pkg::slot_t chosen_q;
	dps_pkg::prio_t newp_q;
	dps_pkg::rtime_t tleft_q;
	logic fin_q;

	logic out_free;
	logic req_fire;
	logic occ_s1;
	logic take_s1;
	logic upd_go;
	logic use_last;
	logic [IDX_W-1:0] sel_idx;
	dps_pkg::prio_t sel_prio;
	dps_pkg::rtime_t sel_time;
	dps_pkg::prio_t dec_prio;
	dps_pkg::rtime_t dec_time;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	dps_pkg::prio_t wr_prio;
	dps_pkg::rtime_t wr_time;
	logic load_hit;

	assign out_free = !ov_q || rsp.ready;
	assign req.ready = (state_q == dps_pkg::S_IDLE) && out_free;
	assign req_fire = req.valid && req.ready;
	assign load_hit = (int'(req.slot) < SLOTS);

	// Shared compare unit: one slot per cycle against the running best.
	assign occ_s1 = vld_s1 && (time_s1 != '0);
	assign take_s1 = cmp_s1 && occ_s1 && (!found_q || (prio_s1 > best_prio_q));

	// Update step: tie goes to the last-run slot when it matches the best priority.
	assign upd_go = (state_q == dps_pkg::S_UPD) && out_free;
	assign use_last = last_valid_q && last_occ_q && (last_prio_q == best_prio_q);
	assign sel_idx = use_last ? last_slot_q : best_idx_q;
	assign sel_prio = use_last ? last_prio_q : best_prio_q;
	assign sel_time = use_last ? last_time_q : best_time_q;
	assign dec_prio = (sel_prio == dps_pkg::PRIO_MIN) ? sel_prio : sel_prio - 16'sd1;
	assign dec_time = sel_time - 16'd1;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = sel_idx;
		wr_prio = dec_prio;
		wr_time = dec_time;
		if (req_fire && (req.operation == dps_pkg::OP_LOAD)) begin
			wr_en = load_hit;
			wr_addr = IDX_W'(req.slot);
			wr_prio = req.start_priority;
			wr_time = req.run_time;
		end else if (upd_go && found_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prio_mem[wr_addr] <= wr_prio;
			time_mem[wr_addr] <= wr_time;
		end
	end

	always_ff @(posedge clk) begin
		prio_s1 <= prio_mem[cnt_q];
		time_s1 <= time_mem[cnt_q];
		vld_s1 <= valid_q[cnt_q];
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dps_pkg::S_IDLE;
			valid_q <= '0;
			cnt_q <= '0;
			cmp_s1 <= 1'b0;
			found_q <= 1'b0;
			last_occ_q <= 1'b0;
			last_slot_q <= '0;
			last_valid_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			cmp_s1 <= 1'b0;
			case (state_q)
				dps_pkg::S_IDLE: begin
					if (req_fire) begin
						if (req.operation == dps_pkg::OP_TICK) begin
							state_q <= dps_pkg::S_SCAN;
							cnt_q <= '0;
							found_q <= 1'b0;
							last_occ_q <= 1'b0;
						end else begin
							ov_q <= 1'b1;
						end
					end
				end
				dps_pkg::S_SCAN: begin
					cmp_s1 <= 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= dps_pkg::S_DRAIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				dps_pkg::S_DRAIN: begin
					state_q <= dps_pkg::S_UPD;
				end
				dps_pkg::S_UPD: begin
					if (upd_go) begin
						state_q <= dps_pkg::S_IDLE;
						ov_q <= 1'b1;
						cnt_q <= '0;
						if (found_q) begin
							last_slot_q <= sel_idx;
							last_valid_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= dps_pkg::S_IDLE;
				end
			endcase
			if (take_s1) begin
				found_q <= 1'b1;
			end
			if (cmp_s1 && (idx_s1 == last_slot_q)) begin
				last_occ_q <= occ_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			best_idx_q <= idx_s1;
			best_prio_q <= prio_s1;
			best_time_q <= time_s1;
		end
		if (cmp_s1 && (idx_s1 == last_slot_q)) begin
			last_prio_q <= prio_s1;
			last_time_q <= time_s1;
		end
		if (req_fire && (req.operation == dps_pkg::OP_LOAD)) begin
			ran_q <= 1'b0;
			chosen_q <= req.slot;
			newp_q <= req.start_priority;
			tleft_q <= req.run_time;
			fin_q <= 1'b0;
		end else if (upd_go) begin
			if (found_q) begin
				ran_q <= 1'b1;
				chosen_q <= 3'(sel_idx);
				newp_q <= dec_prio;
				tleft_q <= dec_time;
				fin_q <= (dec_time == '0);
			end else begin
				ran_q <= 1'b0;
				chosen_q <= '0;
				newp_q <= '0;
				tleft_q <= '0;
				fin_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.ran = ran_q;
	assign rsp.chosen_slot = chosen_q;
	assign rsp.new_priority = newp_q;
	assign rsp.time_left = tleft_q;
	assign rsp.finished = fin_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (state_q == dps_pkg::S_IDLE))
		else $error("request ready outside the idle state");

	a_tick_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.operation == dps_pkg::OP_TICK)) |=> (state_q == dps_pkg::S_SCAN))
		else $error("tick transaction did not start a scan");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !rsp.ready) |=> (ov_q && $stable(tleft_q) && $stable(chosen_q)))
		else $error("pending result lost or changed while stalled");

	a_finish_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && fin_q) |-> ran_q)
		else $error("finished flag set on a result that did not run");

endmodule
